// File: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// types, status codes and the alphabet lookup of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LENGTH = 3'd1,
        ST_BAD_CHAR   = 3'd2,
        ST_BAD_PAD    = 3'd3,
        ST_OVERFLOW   = 3'd4
    } t_status;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic [5:0] val;
    } t_sextet;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_status     status;
        logic [15:0] count;
    } t_result;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet s;
        logic [7:0] d;
        s = '0;
        d = '0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            d = ch - 8'h41;
            s.valid = 1'b1;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d = ch - 8'h61 + 8'd26;
            s.valid = 1'b1;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30 + 8'd52;
            s.valid = 1'b1;
        end else if (ch == 8'h2B) begin
            d = 8'd62;
            s.valid = 1'b1;
        end else if (ch == 8'h2F) begin
            d = 8'd63;
            s.valid = 1'b1;
        end
        s.val = d[5:0];
        return s;
    endfunction

endpackage

// File: rtl/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d_if
// valid/ready channels of the base64 stream decoder
// ----------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       msg_end;

    modport source (output valid, in_char, msg_end, input ready);
    modport sink (input valid, in_char, msg_end, output ready);
endinterface

interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  out_byte;
    logic [2:0]  status_code;
    logic [15:0] decoded_count;
    logic        final_result;

    modport source (output valid, result_kind, out_byte, status_code, decoded_count,
                    final_result, input ready);
    modport sink (input valid, result_kind, out_byte, status_code, decoded_count,
                  final_result, output ready);
endinterface

interface b64d_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_out_bytes;

    modport source (output valid, max_out_bytes, input ready);
    modport sink (input valid, max_out_bytes, output ready);
endinterface

// File: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// decodes a base64 character stream, one character a word, into data bytes
// and one status word at the end of each message
// ----------------------------------------------------------------------------
//   channel   direction   contents
//   i_in      sink        in_char, msg_end
//   o_out     source      result_kind, out_byte, status_code, decoded_count,
//                         final_result
//   i_cfg     sink        max_out_bytes (always ready)
//
// a character is decoded in the cycle it is taken; its zero to four words
// leave through a four-entry result buffer and an output register
// one word leaves per cycle unless o_out stalls, so a character giving k words
// keeps i_in.ready low until its last word moves; characters giving at most
// one word stream at one per cycle unless o_out stalls; o_out stalls hold the
// output register; i_in is taken while the last buffered word moves out
// synchronous reset returns to group start with max_out_bytes at 65535
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64d_in_if.sink           i_in,
    b64d_out_if.source        o_out,
    b64d_cfg_if.sink          i_cfg
);

    logic [15:0]         r_max;
    logic [1:0]          r_pos;
    logic [5:0]          r_s1;
    logic [5:0]          r_s2;
    logic [5:0]          r_s3;
    logic                r_tinv;
    logic                r_tpad;
    b64d_pkg::t_status   r_err;
    logic [15:0]         r_count;

    b64d_pkg::t_result   r_res [4];
    logic [1:0]          r_head;
    logic [2:0]          r_left;

    b64d_pkg::t_result   r_out;
    logic                r_out_final;
    logic                r_out_valid;

    b64d_pkg::t_sextet   sx;
    logic                is_pad;
    logic                ovf1;
    logic                ovf2;
    logic                ovf3;
    logic [7:0]          byte1;
    logic [7:0]          byte2;
    logic [7:0]          byte3;
    b64d_pkg::t_status   n_err;
    logic [15:0]         n_count;
    logic [1:0]          n_bytes;
    logic [2:0]          n_total;
    b64d_pkg::t_result   n_res [4];

    logic                accept;
    logic                move;

    assign move   = (r_left != 3'd0) && (!r_out_valid || o_out.ready);
    assign accept = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_left == 3'd0) || ((r_left == 3'd1) && move);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_out.kind;
    assign o_out.out_byte      = r_out.data;
    assign o_out.status_code   = r_out.status;
    assign o_out.decoded_count = r_out.count;
    assign o_out.final_result  = r_out_final;

    assign byte1 = {r_s1, r_s2[5:4]};
    assign byte2 = {r_s2[3:0], r_s3[5:2]};

    always_comb begin
        sx     = b64d_pkg::sextet_of(i_in.in_char);
        is_pad = (i_in.in_char == b64d_pkg::PAD_CHAR);
        byte3  = {r_s3[1:0], sx.val};
        ovf1   = ({1'b0, r_count} + 17'd1) > {1'b0, r_max};
        ovf2   = ({1'b0, r_count} + 17'd2) > {1'b0, r_max};
        ovf3   = ({1'b0, r_count} + 17'd3) > {1'b0, r_max};
        n_err   = r_err;
        n_bytes = 2'd0;
        for (int k = 0; k < 4; k++) begin
            n_res[k] = '0;
        end

        if (r_pos != 2'd3) begin
            if (r_pos != 2'd2 && !sx.valid && r_err == b64d_pkg::ST_OK) begin
                n_err = b64d_pkg::ST_BAD_CHAR;
            end
        end else if (r_err == b64d_pkg::ST_OK) begin
            if ((!i_in.msg_end && (r_tpad || is_pad)) || (r_tpad && !is_pad)) begin
                n_err = b64d_pkg::ST_BAD_PAD;
            end else if (ovf1) begin
                n_err = b64d_pkg::ST_OVERFLOW;
            end else begin
                n_res[0].data = byte1;
                n_bytes = 2'd1;
                if (!r_tpad && r_tinv) begin
                    n_err = b64d_pkg::ST_BAD_CHAR;
                end else if (!r_tpad && ovf2) begin
                    n_err = b64d_pkg::ST_OVERFLOW;
                end else begin
                    if (!r_tpad) begin
                        n_res[1].data = byte2;
                        n_bytes = 2'd2;
                    end
                    if (!is_pad) begin
                        if (!sx.valid) begin
                            n_err = b64d_pkg::ST_BAD_CHAR;
                        end else if (r_tpad ? ovf2 : ovf3) begin
                            n_err = b64d_pkg::ST_OVERFLOW;
                        end else begin
                            n_res[n_bytes].data = byte3;
                            n_bytes = n_bytes + 2'd1;
                        end
                    end
                end
            end
        end

        n_count = r_count + {14'd0, n_bytes};
        n_total = {1'b0, n_bytes};
        if (i_in.msg_end) begin
            n_res[n_bytes].kind   = b64d_pkg::KIND_STATUS;
            n_res[n_bytes].status = (r_pos != 2'd3) ? b64d_pkg::ST_BAD_LENGTH : n_err;
            n_res[n_bytes].count  = n_count;
            n_total = n_total + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= 16'hFFFF;
            r_pos       <= 2'd0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_s3        <= '0;
            r_tinv      <= 1'b0;
            r_tpad      <= 1'b0;
            r_err       <= b64d_pkg::ST_OK;
            r_count     <= '0;
            r_head      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_out_final <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_max <= i_cfg.max_out_bytes;
            end

            if (move) begin
                r_out       <= r_res[r_head];
                r_out_final <= (r_left == 3'd1);
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                r_res  <= n_res;
                r_head <= 2'd0;
                r_left <= n_total;
                if (i_in.msg_end) begin
                    r_pos   <= 2'd0;
                    r_s1    <= '0;
                    r_s2    <= '0;
                    r_s3    <= '0;
                    r_tinv  <= 1'b0;
                    r_tpad  <= 1'b0;
                    r_err   <= b64d_pkg::ST_OK;
                    r_count <= '0;
                end else begin
                    r_pos   <= r_pos + 2'd1;
                    r_err   <= n_err;
                    r_count <= n_count;
                    unique case (r_pos)
                        2'd0: r_s1 <= sx.val;
                        2'd1: r_s2 <= sx.val;
                        2'd2: begin
                            r_s3   <= sx.val;
                            r_tinv <= !sx.valid;
                            r_tpad <= is_pad;
                        end
                        default: ;
                    endcase
                end
            end else if (move) begin
                r_head <= r_head + 2'd1;
                r_left <= r_left - 3'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > 3'd1) |-> !i_in.ready)
        else $error("input taken with more than one word buffered");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind) |-> o_out.final_result)
        else $error("status word not marked final");

    a_end_restarts_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.msg_end) |=> (r_pos == 2'd0 && r_count == 16'd0))
        else $error("message end did not clear the group state");
`endif

endmodule

// File: tb/tb_base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// self-checking bench: a directed table of text and flaws, then random
// messages under several byte limits and handshake idling patterns; every
// result word is compared with a cycle-free decoder kept in the bench
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        b64d_pkg::t_kind   kind;
        logic [7:0]        data;
        b64d_pkg::t_status status;
        logic [15:0]       count;
        logic              fin;
    } t_word;

    typedef struct {
        logic [7:0]        ch;
        logic              last;
        bit                typed;
        b64d_pkg::t_status st;
        logic [15:0]       cnt;
    } t_row;

    localparam int NUM_ROWS = 26;
    localparam int PHASE_CHARS = 35;
    localparam int SETTLE_CYCLES = 16;

    logic i_clk = 1'b0;
    logic i_rst_n;

    b64d_in_if  in_if ();
    b64d_out_if out_if ();
    b64d_cfg_if cfg_if ();

    base64_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #4ns i_clk = ~i_clk;

    t_row dir_tab [0:NUM_ROWS-1] = '{
        '{"T", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"W", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"F", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"u", 1'b1, 1'b1, b64d_pkg::ST_OK, 16'd3},
        '{"A", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"A", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"=", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"=", 1'b1, 1'b1, b64d_pkg::ST_OK, 16'd1},
        '{"/", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"/", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"/", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"/", 1'b1, 1'b1, b64d_pkg::ST_OK, 16'd3},
        '{"A", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{8'hFF, 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"A", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"A", 1'b1, 1'b1, b64d_pkg::ST_BAD_CHAR, 16'd0},
        '{8'h00, 1'b1, 1'b1, b64d_pkg::ST_BAD_LENGTH, 16'd0},
        '{"A", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"B", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"=", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"C", 1'b1, 1'b1, b64d_pkg::ST_BAD_PAD, 16'd0},
        '{"z", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"9", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"+", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"=", 1'b0, 1'b0, b64d_pkg::ST_OK, 16'd0},
        '{"0", 1'b1, 1'b1, b64d_pkg::ST_BAD_LENGTH, 16'd0}
    };

    t_word             decoded_words [$];
    int                mismatch_cnt = 0;
    int                chars_sent = 0;
    int                in_idle_pct = 0;
    int                out_stall_pct = 0;

    logic              tag_typed;
    b64d_pkg::t_status tag_st;
    logic [15:0]       tag_cnt;

    logic [15:0]       limit_bytes;
    logic [1:0]        grp_pos;
    logic [5:0]        s0, s1, s2;
    logic              s2_bad, s2_pad;
    b64d_pkg::t_status err_code;
    logic [15:0]       byte_cnt;

    function automatic void clear_msg();
        grp_pos = 2'd0;
        s0 = 6'd0;
        s1 = 6'd0;
        s2 = 6'd0;
        s2_bad = 1'b0;
        s2_pad = 1'b0;
        err_code = b64d_pkg::ST_OK;
        byte_cnt = 16'd0;
    endfunction

    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        if (c >= "A" && c <= "Z") begin
            d = c - "A";
        end else if (c >= "a" && c <= "z") begin
            d = c - "a" + 8'd26;
        end else if (c >= "0" && c <= "9") begin
            d = c - "0" + 8'd52;
        end else if (c == "+") begin
            d = 8'd62;
        end else if (c == "/") begin
            d = 8'd63;
        end else begin
            return 7'd0;
        end
        return {1'b1, d[5:0]};
    endfunction

    function automatic logic [7:0] b64_char(input int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic void latch_err(input b64d_pkg::t_status c);
        if (err_code == b64d_pkg::ST_OK) err_code = c;
    endfunction

    function automatic bit push_byte(input logic [7:0] b);
        if (int'(byte_cnt) + 1 > int'(limit_bytes)) begin
            latch_err(b64d_pkg::ST_OVERFLOW);
            return 1'b0;
        end
        decoded_words.push_back(t_word'{b64d_pkg::KIND_DATA, b, b64d_pkg::ST_OK,
                                        16'd0, 1'b0});
        byte_cnt = byte_cnt + 16'd1;
        return 1'b1;
    endfunction

    function automatic void decode_char(input logic [7:0] ch, input logic last,
                                        input logic typed, input b64d_pkg::t_status st,
                                        input logic [15:0] cnt);
        logic [6:0] cv;
        logic       ok;
        logic [5:0] v;
        logic       pad;
        logic [1:0] pos;
        int         n0;
        bit         go;
        t_word      w;
        cv = char_value(ch);
        ok = cv[6];
        v = cv[5:0];
        pad = (ch == b64d_pkg::PAD_CHAR);
        pos = grp_pos;
        n0 = decoded_words.size();
        go = 1'b1;
        case (pos)
            2'd0: begin
                s0 = v;
                if (!ok) latch_err(b64d_pkg::ST_BAD_CHAR);
            end
            2'd1: begin
                s1 = v;
                if (!ok) latch_err(b64d_pkg::ST_BAD_CHAR);
            end
            2'd2: begin
                s2 = v;
                s2_bad = !ok;
                s2_pad = pad;
            end
            default: begin
                if (err_code == b64d_pkg::ST_OK) begin
                    if (!last && (s2_pad || pad)) begin
                        latch_err(b64d_pkg::ST_BAD_PAD);
                    end else if (s2_pad && !pad) begin
                        latch_err(b64d_pkg::ST_BAD_PAD);
                    end else if (push_byte({s0, s1[5:4]})) begin
                        if (!s2_pad) begin
                            if (s2_bad) begin
                                latch_err(b64d_pkg::ST_BAD_CHAR);
                                go = 1'b0;
                            end else begin
                                go = push_byte({s1[3:0], s2[5:2]});
                            end
                        end
                        if (go && !pad) begin
                            if (!ok) latch_err(b64d_pkg::ST_BAD_CHAR);
                            else void'(push_byte({s2[1:0], v}));
                        end
                    end
                end
            end
        endcase
        grp_pos = pos + 2'd1;
        if (last) begin
            w = t_word'{b64d_pkg::KIND_STATUS, 8'd0,
                        (pos != 2'd3) ? b64d_pkg::ST_BAD_LENGTH : err_code,
                        byte_cnt, 1'b0};
            if (typed) begin
                w.status = st;
                w.count = cnt;
            end
            decoded_words.push_back(w);
            clear_msg();
        end
        if (decoded_words.size() > n0) begin
            w = decoded_words.pop_back();
            w.fin = 1'b1;
            decoded_words.push_back(w);
        end
    endfunction

    function automatic string word_str(input t_word w);
        return $sformatf("kind=%0d byte=%h st=%0d cnt=%0d fin=%0d",
                         w.kind, w.data, w.status, w.count, w.fin);
    endfunction

    function automatic void check_word();
        t_word e;
        t_word a;
        a = t_word'{b64d_pkg::t_kind'(out_if.result_kind), out_if.out_byte,
                    b64d_pkg::t_status'(out_if.status_code), out_if.decoded_count,
                    out_if.final_result};
        if (decoded_words.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("unexpected word: %s", word_str(a));
        end else begin
            e = decoded_words.pop_front();
            if (a !== e) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("mismatch: exp %s, got %s", word_str(e), word_str(a));
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_bytes = 16'hFFFF;
            clear_msg();
        end else begin
            if (cfg_if.valid && cfg_if.ready) limit_bytes = cfg_if.max_out_bytes;
            if (in_if.valid && in_if.ready)
                decode_char(in_if.in_char, in_if.msg_end, tag_typed, tag_st, tag_cnt);
            if (out_if.valid && out_if.ready) check_word();
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task automatic send_word(input logic [7:0] ch, input logic last, input logic typed,
                             input b64d_pkg::t_status st, input logic [15:0] cnt);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.in_char <= ch;
        in_if.msg_end <= last;
        tag_typed <= typed;
        tag_st <= st;
        tag_cnt <= cnt;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic drain_results(input int extra);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_words.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.max_out_bytes <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random_message();
        logic [7:0] text [$];
        int         groups;
        int         len;
        int         flaw;
        int         k;
        groups = ($urandom_range(7) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 3);
        for (k = 0; k < groups * 4; k++) text.push_back(b64_char($urandom_range(63)));
        len = text.size();
        case ($urandom_range(2))
            1: text[len-1] = b64d_pkg::PAD_CHAR;
            2: begin
                text[len-1] = b64d_pkg::PAD_CHAR;
                text[len-2] = b64d_pkg::PAD_CHAR;
            end
            default: ;
        endcase
        flaw = $urandom_range(99);
        if (flaw < 70) begin
        end else if (flaw < 78) begin
            text[$urandom_range(len - 1)] = 8'($urandom_range(255));
        end else if (flaw < 84) begin
            text[$urandom_range(len - 1)] = b64d_pkg::PAD_CHAR;
        end else if (flaw < 90) begin
            k = $urandom_range(1, len - 1);
            while (text.size() > k) void'(text.pop_back());
        end else if (flaw < 95) begin
            repeat ($urandom_range(1, 3)) text.push_back(b64_char($urandom_range(63)));
        end else begin
            text.delete();
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
        end
        for (k = 0; k < text.size(); k++)
            send_word(text[k], k == text.size() - 1, 1'b0, b64d_pkg::ST_OK, 16'd0);
    endtask

    initial begin
        int          p;
        int          k;
        bit          paused;
        logic [15:0] lim;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_char = 8'd0;
        in_if.msg_end = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.max_out_bytes = 16'd0;
        tag_typed = 1'b0;
        tag_st = b64d_pkg::ST_OK;
        tag_cnt = 16'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < NUM_ROWS; k++)
            send_word(dir_tab[k].ch, dir_tab[k].last, dir_tab[k].typed,
                      dir_tab[k].st, dir_tab[k].cnt);

        for (p = 0; p < 8; p++) begin
            drain_results(SETTLE_CYCLES);
            case (p)
                0: lim = 16'hFFFF;
                1: lim = 16'd0;
                2: lim = 16'd1;
                3: lim = 16'd2;
                4: lim = 16'($urandom_range(3, 12));
                5: lim = 16'($urandom_range(13, 60));
                6: lim = 16'hFFFE;
                default: lim = 16'hFFFF;
            endcase
            write_limit(lim);
            case (p % 4)
                0: begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct = 57;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct = 0;
                    out_stall_pct = 57;
                end
                default: begin
                    in_idle_pct = 30;
                    out_stall_pct = 30;
                end
            endcase
            chars_sent = 0;
            paused = 1'b0;
            while (chars_sent < PHASE_CHARS) begin
                send_random_message();
                if (!paused && chars_sent >= PHASE_CHARS / 2) begin
                    drain_results(0);
                    paused = 1'b1;
                end
            end
        end

        drain_results(SETTLE_CYCLES);
        if (mismatch_cnt == 0 && decoded_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/base64_stream_decoder.sv
tb/tb_base64_stream_decoder.sv
